### rtl/gak_pkg.sv
// ----------------------------------------------------------------------------
// gak_pkg
// Shared types, constants and fixed-point helpers of the gyro/angle Kalman
// filter.
// ----------------------------------------------------------------------------
package gak_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int COV_FRAC_BITS   = 32;
  localparam int DT_FRAC         = 16;
  localparam int GAIN_FRAC       = 30;

  localparam int WIDE     = 58;
  localparam int PROD_W   = 56;
  localparam int MUL_A_W  = 50;
  localparam int MUL_B_W  = 33;
  localparam int COV_W    = 48;
  localparam int VAL_W    = 32;
  localparam int NOISE_UP = (COV_FRAC_BITS >= 32) ? COV_FRAC_BITS - 32 : 0;
  localparam int NOISE_DN = (COV_FRAC_BITS < 32) ? 32 - COV_FRAC_BITS : 0;

  localparam logic [31:0] RST_NOISE_ANGLE = 32'd85899;
  localparam logic [31:0] RST_NOISE_BIAS  = 32'd429496730;
  localparam logic [31:0] RST_NOISE_MEAS  = 32'd1288490189;

  localparam logic [1:0] REG_NOISE_ANGLE = 2'd0;
  localparam logic [1:0] REG_NOISE_BIAS  = 2'd1;
  localparam logic [1:0] REG_NOISE_MEAS  = 2'd2;

  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  typedef logic signed [WIDE-1:0]   wide_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_DT2,
    OP_RATE,
    OP_CROSS,
    OP_C11DT2,
    OP_C11DT,
    OP_PCOMMIT,
    OP_INIT,
    OP_DIV0,
    OP_DIV1,
    OP_K0Y,
    OP_K1Y,
    OP_K0C00,
    OP_K0C01,
    OP_K1C00,
    OP_K1C01,
    OP_UCOMMIT,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic s_bad;
    logic out_free;
  } sts_t;

  localparam wide_t MAX32 = wide_t'(64'sd2147483647);
  localparam wide_t MIN32 = -MAX32 - wide_t'(1);
  localparam wide_t MAX48 = wide_t'(64'sd140737488355327);
  localparam wide_t MIN48 = -MAX48 - wide_t'(1);

  function automatic logic signed [VAL_W-1:0] sat32(wide_t x);
    if (x > MAX32) begin
      return MAX32[VAL_W-1:0];
    end else if (x < MIN32) begin
      return MIN32[VAL_W-1:0];
    end
    return x[VAL_W-1:0];
  endfunction

  function automatic logic signed [COV_W-1:0] sat48(wide_t x);
    if (x > MAX48) begin
      return MAX48[COV_W-1:0];
    end else if (x < MIN48) begin
      return MIN48[COV_W-1:0];
    end
    return x[COV_W-1:0];
  endfunction

  function automatic wide_t noise_to_cov(logic [31:0] v);
    logic [WIDE-1:0] ext;
    logic [WIDE-1:0] half;
    ext  = {{(WIDE-32){1'b0}}, v};
    half = (WIDE'(1) << NOISE_DN) >> 1;
    return $signed(((ext + half) >> NOISE_DN) << NOISE_UP);
  endfunction

endpackage

### rtl/gak_in_if.sv
// ----------------------------------------------------------------------------
// gak_in_if
// Input channel: predict or update item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gak_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] gyro_rate;
  logic [15:0]        time_step;
  logic signed [31:0] measured_angle;

  modport source (output valid, cmd, gyro_rate, time_step, measured_angle, input ready);
  modport sink   (input valid, cmd, gyro_rate, time_step, measured_angle, output ready);
endinterface

### rtl/gak_out_if.sv
// ----------------------------------------------------------------------------
// gak_out_if
// Output channel: angle and bias estimate with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gak_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] bias_estimate;

  modport source (output valid, angle_estimate, bias_estimate, input ready);
  modport sink   (input valid, angle_estimate, bias_estimate, output ready);
endinterface

### rtl/gak_mul.sv
// ----------------------------------------------------------------------------
// gak_mul
// Multi-cycle signed multiplier: two partial products, accumulate, then
// round half up and shift by the time-step or gain fraction.
// ----------------------------------------------------------------------------
module gak_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [gak_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [gak_pkg::MUL_B_W-1:0] b_i,
  input  logic                               gain_i,
  output logic                               done_o,
  output gak_pkg::prod_t                     p_o
);

  localparam int SPLIT = 25;
  localparam int PP_W  = SPLIT + 1 + gak_pkg::MUL_B_W;
  localparam int ACC_W = gak_pkg::MUL_A_W + gak_pkg::MUL_B_W;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t HALF_DT   = acc_t'(1) <<< (gak_pkg::DT_FRAC - 1);
  localparam acc_t HALF_GAIN = acc_t'(1) <<< (gak_pkg::GAIN_FRAC - 1);

  logic [2:0]                         phase_q;
  logic                               done_q;
  logic signed [gak_pkg::MUL_A_W-1:0] a_q;
  logic signed [gak_pkg::MUL_B_W-1:0] b_q;
  logic                               gain_q;
  logic signed [PP_W-1:0]             prod_q;
  acc_t                               acc_q;
  gak_pkg::prod_t                     p_q;
  acc_t                               rnd;
  acc_t                               shifted;

  assign rnd     = acc_q + (gain_q ? HALF_GAIN : HALF_DT);
  assign shifted = gain_q ? (rnd >>> gak_pkg::GAIN_FRAC) : (rnd >>> gak_pkg::DT_FRAC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 3'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        phase_q <= 3'd1;
      end else if (phase_q == 3'd4) begin
        phase_q <= 3'd0;
        done_q  <= 1'b1;
      end else if (phase_q != 3'd0) begin
        phase_q <= phase_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      gain_q <= gain_i;
    end
    case (phase_q)
      3'd1: prod_q <= $signed({1'b0, a_q[SPLIT-1:0]}) * b_q;
      3'd2: begin
        acc_q  <= acc_t'(prod_q);
        prod_q <= $signed(a_q[gak_pkg::MUL_A_W-1:SPLIT]) * b_q;
      end
      3'd3: acc_q <= acc_q + (acc_t'(prod_q) <<< SPLIT);
      3'd4: p_q <= shifted[gak_pkg::PROD_W-1:0];
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

### rtl/gak_div.sv
// ----------------------------------------------------------------------------
// gak_div
// Restoring divider for the Kalman gains: signed Q1.30 quotient of a
// covariance over a positive innovation variance, saturated below 2.
// ----------------------------------------------------------------------------
module gak_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [gak_pkg::COV_W-1:0] num_i,
  input  logic [gak_pkg::COV_W-1:0]        den_i,
  output logic                             done_o,
  output logic signed [gak_pkg::VAL_W-1:0] q_o
);

  localparam int STEPS = gak_pkg::GAIN_FRAC + 1;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int R_W   = gak_pkg::COV_W + 2;

  logic [CNT_W-1:0]         cnt_q;
  logic                     done_q;
  logic                     neg_q;
  logic                     sat_q;
  logic [gak_pkg::COV_W-1:0] d_q;
  logic [R_W-1:0]           r_q;
  logic [STEPS-1:0]         q_q;
  logic [gak_pkg::COV_W-1:0] mag;
  logic                     ge;
  logic [R_W-1:0]           r_sub;
  logic [STEPS-1:0]         q_mag;

  assign mag   = num_i[gak_pkg::COV_W-1] ? gak_pkg::COV_W'(-num_i) : gak_pkg::COV_W'(num_i);
  assign ge    = r_q >= {2'b00, d_q};
  assign r_sub = ge ? r_q - {2'b00, d_q} : r_q;
  assign q_mag = sat_q ? {STEPS{1'b1}} : q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(STEPS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[gak_pkg::COV_W-1];
      d_q   <= den_i;
      r_q   <= {2'b00, mag};
      sat_q <= {2'b00, mag} >= {1'b0, den_i, 1'b0};
      q_q   <= '0;
    end else if (cnt_q != '0) begin
      q_q <= {q_q[STEPS-2:0], ge};
      r_q <= {r_sub[R_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

endmodule

### rtl/gak_datapath.sv
// ----------------------------------------------------------------------------
// gak_datapath
// Filter state, temporaries, shared multiplier and divider, output register.
// Executes one operation per command from the controller.
// ----------------------------------------------------------------------------
module gak_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gak_pkg::cmd_t                    cmd_i,
  output gak_pkg::sts_t                    sts_o,
  input  logic                             accept_i,
  input  logic signed [31:0]               gyro_rate_i,
  input  logic [15:0]                      time_step_i,
  input  logic signed [31:0]               measured_angle_i,
  input  logic [31:0]                      noise_angle_i,
  input  logic [31:0]                      noise_bias_i,
  input  logic [31:0]                      noise_meas_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic signed [31:0]               angle_estimate_o,
  output logic signed [31:0]               bias_estimate_o
);

  typedef logic signed [gak_pkg::MUL_A_W-1:0] mul_a_t;
  typedef logic signed [gak_pkg::MUL_B_W-1:0] mul_b_t;
  typedef logic signed [gak_pkg::COV_W-1:0]   cov_t;
  typedef logic signed [gak_pkg::VAL_W-1:0]   val_t;

  val_t            rate_q, meas_q, angle_q, bias_q, y_q, k0_q, k1_q;
  logic [15:0]     dt_q;
  cov_t            c00_q, c01_q, c10_q, c11_q;
  logic [gak_pkg::COV_W-1:0] s_q;
  logic            s_bad_q;
  gak_pkg::prod_t  tmp_q [6];
  logic            simple_done_q;
  logic            out_valid_q;
  val_t            out_angle_q, out_bias_q;

  logic            is_mul, is_div, is_simple;
  mul_a_t          mul_a;
  mul_b_t          mul_b;
  logic            mul_gain;
  logic [2:0]      slot;
  logic            mul_done, div_done;
  gak_pkg::prod_t  mul_p;
  cov_t            div_num;
  val_t            div_q;
  gak_pkg::wide_t  s_w;
  mul_a_t          dt_a;
  mul_b_t          dt_b;

  assign is_mul = cmd_i.op inside {gak_pkg::OP_DT2, gak_pkg::OP_RATE, gak_pkg::OP_CROSS,
                                   gak_pkg::OP_C11DT2, gak_pkg::OP_C11DT, gak_pkg::OP_K0Y,
                                   gak_pkg::OP_K1Y, gak_pkg::OP_K0C00, gak_pkg::OP_K0C01,
                                   gak_pkg::OP_K1C00, gak_pkg::OP_K1C01};
  assign is_div = cmd_i.op inside {gak_pkg::OP_DIV0, gak_pkg::OP_DIV1};
  assign is_simple = cmd_i.op inside {gak_pkg::OP_PCOMMIT, gak_pkg::OP_INIT,
                                      gak_pkg::OP_UCOMMIT, gak_pkg::OP_OUT};

  assign dt_a = mul_a_t'($signed({1'b0, dt_q}));
  assign dt_b = mul_b_t'($signed({1'b0, dt_q}));

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_gain = 1'b0;
    slot     = 3'd0;
    case (cmd_i.op)
      gak_pkg::OP_DT2: begin
        mul_a = dt_a;
        mul_b = dt_b;
        slot  = 3'd4;
      end
      gak_pkg::OP_RATE: begin
        mul_a = mul_a_t'(rate_q) - mul_a_t'(bias_q);
        mul_b = dt_b;
        slot  = 3'd0;
      end
      gak_pkg::OP_CROSS: begin
        mul_a = mul_a_t'(c10_q) + mul_a_t'(c01_q);
        mul_b = dt_b;
        slot  = 3'd1;
      end
      gak_pkg::OP_C11DT2: begin
        mul_a = mul_a_t'(c11_q);
        mul_b = mul_b_t'($signed({1'b0, tmp_q[4][15:0]}));
        slot  = 3'd2;
      end
      gak_pkg::OP_C11DT: begin
        mul_a = mul_a_t'(c11_q);
        mul_b = dt_b;
        slot  = 3'd3;
      end
      gak_pkg::OP_K0Y: begin
        mul_a    = mul_a_t'(y_q);
        mul_b    = mul_b_t'(k0_q);
        mul_gain = 1'b1;
        slot     = 3'd0;
      end
      gak_pkg::OP_K1Y: begin
        mul_a    = mul_a_t'(y_q);
        mul_b    = mul_b_t'(k1_q);
        mul_gain = 1'b1;
        slot     = 3'd1;
      end
      gak_pkg::OP_K0C00: begin
        mul_a    = mul_a_t'(c00_q);
        mul_b    = mul_b_t'(k0_q);
        mul_gain = 1'b1;
        slot     = 3'd2;
      end
      gak_pkg::OP_K0C01: begin
        mul_a    = mul_a_t'(c01_q);
        mul_b    = mul_b_t'(k0_q);
        mul_gain = 1'b1;
        slot     = 3'd3;
      end
      gak_pkg::OP_K1C00: begin
        mul_a    = mul_a_t'(c00_q);
        mul_b    = mul_b_t'(k1_q);
        mul_gain = 1'b1;
        slot     = 3'd4;
      end
      gak_pkg::OP_K1C01: begin
        mul_a    = mul_a_t'(c01_q);
        mul_b    = mul_b_t'(k1_q);
        mul_gain = 1'b1;
        slot     = 3'd5;
      end
      default: ;
    endcase
  end

  assign div_num = (cmd_i.op == gak_pkg::OP_DIV1) ? c10_q : c00_q;
  assign s_w     = gak_pkg::wide_t'(c00_q) + gak_pkg::noise_to_cov(noise_meas_i);

  gak_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && is_mul),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .gain_i  (mul_gain),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  gak_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && is_div),
    .num_i   (div_num),
    .den_i   (s_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q       <= '0;
      bias_q        <= '0;
      c00_q         <= '0;
      c01_q         <= '0;
      c10_q         <= '0;
      c11_q         <= '0;
      s_bad_q       <= 1'b0;
      simple_done_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      simple_done_q <= cmd_i.start && is_simple;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.start) begin
        case (cmd_i.op)
          gak_pkg::OP_PCOMMIT: begin
            angle_q <= gak_pkg::sat32(gak_pkg::wide_t'(angle_q) + gak_pkg::wide_t'(tmp_q[0]));
            c00_q   <= gak_pkg::sat48(gak_pkg::wide_t'(c00_q) - gak_pkg::wide_t'(tmp_q[1])
                                      + gak_pkg::wide_t'(tmp_q[2])
                                      + gak_pkg::noise_to_cov(noise_angle_i));
            c01_q   <= gak_pkg::sat48(gak_pkg::wide_t'(c01_q) - gak_pkg::wide_t'(tmp_q[3]));
            c10_q   <= gak_pkg::sat48(gak_pkg::wide_t'(c10_q) - gak_pkg::wide_t'(tmp_q[3]));
            c11_q   <= gak_pkg::sat48(gak_pkg::wide_t'(c11_q)
                                      + gak_pkg::noise_to_cov(noise_bias_i));
          end
          gak_pkg::OP_INIT: begin
            s_bad_q <= s_w <= gak_pkg::wide_t'(0);
          end
          gak_pkg::OP_UCOMMIT: begin
            angle_q <= gak_pkg::sat32(gak_pkg::wide_t'(angle_q) + gak_pkg::wide_t'(tmp_q[0]));
            bias_q  <= gak_pkg::sat32(gak_pkg::wide_t'(bias_q) + gak_pkg::wide_t'(tmp_q[1]));
            c00_q   <= gak_pkg::sat48(gak_pkg::wide_t'(c00_q) - gak_pkg::wide_t'(tmp_q[2]));
            c01_q   <= gak_pkg::sat48(gak_pkg::wide_t'(c01_q) - gak_pkg::wide_t'(tmp_q[3]));
            c10_q   <= gak_pkg::sat48(gak_pkg::wide_t'(c10_q) - gak_pkg::wide_t'(tmp_q[4]));
            c11_q   <= gak_pkg::sat48(gak_pkg::wide_t'(c11_q) - gak_pkg::wide_t'(tmp_q[5]));
          end
          gak_pkg::OP_OUT: begin
            out_valid_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rate_q <= gyro_rate_i;
      dt_q   <= time_step_i;
      meas_q <= measured_angle_i;
    end
    if (cmd_i.start && cmd_i.op == gak_pkg::OP_INIT) begin
      y_q <= gak_pkg::sat32(gak_pkg::wide_t'(meas_q) - gak_pkg::wide_t'(angle_q));
      s_q <= s_w[gak_pkg::COV_W-1:0];
    end
    if (cmd_i.start && cmd_i.op == gak_pkg::OP_OUT) begin
      out_angle_q <= angle_q;
      out_bias_q  <= bias_q;
    end
    if (mul_done) begin
      tmp_q[slot] <= mul_p;
    end
    if (div_done) begin
      if (cmd_i.op == gak_pkg::OP_DIV1) begin
        k1_q <= div_q;
      end else begin
        k0_q <= div_q;
      end
    end
  end

  assign sts_o.done     = mul_done || div_done || simple_done_q;
  assign sts_o.s_bad    = s_bad_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign angle_estimate_o = out_angle_q;
  assign bias_estimate_o  = out_bias_q;

endmodule

### rtl/gak_ctrl.sv
// ----------------------------------------------------------------------------
// gak_ctrl
// Sequencer for predict and update items: issues one datapath operation at a
// time and waits for its completion.
// ----------------------------------------------------------------------------
module gak_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_cmd_i,
  output logic          in_ready_o,
  output gak_pkg::cmd_t cmd_o,
  input  gak_pkg::sts_t sts_i
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P_DT2,
    ST_P_RATE,
    ST_P_CROSS,
    ST_P_C11DT2,
    ST_P_C11DT,
    ST_P_COMMIT,
    ST_U_INIT,
    ST_U_DIV0,
    ST_U_DIV1,
    ST_U_K0Y,
    ST_U_K1Y,
    ST_U_K0C00,
    ST_U_K0C01,
    ST_U_K1C00,
    ST_U_K1C01,
    ST_U_COMMIT,
    ST_DONE
  } state_e;

  state_e        state_q;
  logic          issued_q;
  gak_pkg::cmd_t cmd_q;
  gak_pkg::op_e  op_d;
  state_e        next_d;

  always_comb begin
    op_d   = gak_pkg::OP_NONE;
    next_d = ST_DONE;
    case (state_q)
      ST_P_DT2:    begin op_d = gak_pkg::OP_DT2;     next_d = ST_P_RATE;   end
      ST_P_RATE:   begin op_d = gak_pkg::OP_RATE;    next_d = ST_P_CROSS;  end
      ST_P_CROSS:  begin op_d = gak_pkg::OP_CROSS;   next_d = ST_P_C11DT2; end
      ST_P_C11DT2: begin op_d = gak_pkg::OP_C11DT2;  next_d = ST_P_C11DT;  end
      ST_P_C11DT:  begin op_d = gak_pkg::OP_C11DT;   next_d = ST_P_COMMIT; end
      ST_P_COMMIT: begin op_d = gak_pkg::OP_PCOMMIT; next_d = ST_DONE;     end
      ST_U_INIT:   begin op_d = gak_pkg::OP_INIT;    next_d = ST_U_DIV0;   end
      ST_U_DIV0:   begin op_d = gak_pkg::OP_DIV0;    next_d = ST_U_DIV1;   end
      ST_U_DIV1:   begin op_d = gak_pkg::OP_DIV1;    next_d = ST_U_K0Y;    end
      ST_U_K0Y:    begin op_d = gak_pkg::OP_K0Y;     next_d = ST_U_K1Y;    end
      ST_U_K1Y:    begin op_d = gak_pkg::OP_K1Y;     next_d = ST_U_K0C00;  end
      ST_U_K0C00:  begin op_d = gak_pkg::OP_K0C00;   next_d = ST_U_K0C01;  end
      ST_U_K0C01:  begin op_d = gak_pkg::OP_K0C01;   next_d = ST_U_K1C00;  end
      ST_U_K1C00:  begin op_d = gak_pkg::OP_K1C00;   next_d = ST_U_K1C01;  end
      ST_U_K1C01:  begin op_d = gak_pkg::OP_K1C01;   next_d = ST_U_COMMIT; end
      ST_U_COMMIT: begin op_d = gak_pkg::OP_UCOMMIT; next_d = ST_DONE;     end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      cmd_q    <= '{op: gak_pkg::OP_NONE, start: 1'b0};
    end else begin
      cmd_q.start <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= (in_cmd_i == gak_pkg::CMD_UPDATE) ? ST_U_INIT : ST_P_DT2;
          end
        end
        ST_DONE: begin
          if (sts_i.out_free) begin
            cmd_q.op    <= gak_pkg::OP_OUT;
            cmd_q.start <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          if (!issued_q) begin
            issued_q    <= 1'b1;
            cmd_q.op    <= op_d;
            cmd_q.start <= 1'b1;
          end else if (sts_i.done) begin
            issued_q <= 1'b0;
            // skip the correction when the innovation variance is not positive
            state_q  <= (state_q == ST_U_INIT && sts_i.s_bad) ? ST_DONE : next_d;
          end
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o      = cmd_q;

endmodule

### rtl/gyro_angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// gyro_angle_kalman_filter
// Two-state angle/gyro-bias Kalman filter, fixed point, saturating.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one transaction per item; cmd 0 predicts with gyro_rate and
//            time_step, cmd 1 updates with measured_angle.
//   out_o  : one transaction per item with the angle and bias after it.
//   APB    : three noise registers at byte addresses 0, 4 and 8; write only
//            while no item is in flight. pready is always high.
// Sequencing:
//   One item at a time. Processing time is set by the shared multiplier
//   (11 products: five per predict, six per update) and the divider (one
//   gain per divide, two per update); an update with non-positive innovation
//   variance ends after its init step, with no divide or product.
// Reset:
//   Estimates and covariance clear to zero, noise registers take their
//   defaults, no result is pending.
// Stall:
//   The result register holds while out_o.ready is low; a new item is still
//   accepted and processed, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module gyro_angle_kalman_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  gak_in_if.sink      in_i,
  gak_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]   noise_angle_q, noise_bias_q, noise_meas_q;
  logic          cfg_wr;
  logic          accept;
  gak_pkg::cmd_t cmd;
  gak_pkg::sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_angle_q <= gak_pkg::RST_NOISE_ANGLE;
      noise_bias_q  <= gak_pkg::RST_NOISE_BIAS;
      noise_meas_q  <= gak_pkg::RST_NOISE_MEAS;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        gak_pkg::REG_NOISE_ANGLE: noise_angle_q <= pwdata;
        gak_pkg::REG_NOISE_BIAS:  noise_bias_q  <= pwdata;
        gak_pkg::REG_NOISE_MEAS:  noise_meas_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      gak_pkg::REG_NOISE_ANGLE: prdata = noise_angle_q;
      gak_pkg::REG_NOISE_BIAS:  prdata = noise_bias_q;
      gak_pkg::REG_NOISE_MEAS:  prdata = noise_meas_q;
      default:                  prdata = '0;
    endcase
  end

  assign accept = in_i.valid && in_i.ready;

  gak_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  gak_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .accept_i         (accept),
    .gyro_rate_i      (in_i.gyro_rate),
    .time_step_i      (in_i.time_step),
    .measured_angle_i (in_i.measured_angle),
    .noise_angle_i    (noise_angle_q),
    .noise_bias_i     (noise_bias_q),
    .noise_meas_i     (noise_meas_q),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .angle_estimate_o (out_o.angle_estimate),
    .bias_estimate_o  (out_o.bias_estimate)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready)
    else $error("input still ready right after an accepted item");

  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_wr |=> $stable(noise_angle_q) && $stable(noise_bias_q) && $stable(noise_meas_q))
    else $error("noise register changed without a write");

  a_out_only_when_idle_or_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.start && cmd.op == gak_pkg::OP_OUT) |-> in_i.ready)
    else $error("result loaded while an item is still being processed");
`endif

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gyro/angle Kalman filter: directed and random predict and
// update transactions under random stalls, checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] rate;
    logic [15:0]        dt;
    logic signed [31:0] meas;
  } item_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } est_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  gak_in_if  in_ch ();
  gak_out_if out_ch ();

  gyro_angle_kalman_filter uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  item_t pending_items[$];
  est_t  expected_estimates[$];
  int    mismatch_count = 0;
  bit    idle_enable = 1'b1;
  int    in_gap = 0, out_gap = 0;

  logic [31:0] q_angle, q_bias, r_meas;
  longint angle_m, bias_m, p00, p01, p10, p11;

  function automatic longint fshr(longint x, int n);
    return x >= 0 ? (x >>> n) : (-1 - ((-1 - x) >>> n));
  endfunction

  function automatic longint clip(longint x, int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
  endfunction

  function automatic longint mulr(longint a, longint b, int n);
    longint lo, hi;
    lo = a & ((longint'(1) << n) - 1);
    hi = (a - lo) / (longint'(1) << n);
    return hi * b + fshr(lo * b + (longint'(1) << (n - 1)), n);
  endfunction

  function automatic longint noise_cov(logic [31:0] v);
    longint u;
    u = longint'({32'd0, v});
    if (gak_pkg::COV_FRAC_BITS < 32)
      return (u + (longint'(1) << (31 - gak_pkg::COV_FRAC_BITS)))
             >>> (32 - gak_pkg::COV_FRAC_BITS);
    return u << (gak_pkg::COV_FRAC_BITS - 32);
  endfunction

  function automatic longint gain_quot(longint num, longint den);
    bit neg;
    longint unsigned mag, d, q, r;
    neg = num < 0;
    mag = neg ? -num : num;
    d = den;
    q = mag / d;
    if (q >= 2) begin
      q = 64'h7FFF_FFFF;
    end else begin
      r = mag - q * d;
      for (int i = 0; i < gak_pkg::GAIN_FRAC; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 64'd1;
        end
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic void filter_step(item_t it);
    longint a00, a01, a10, a11, dt, dt2, t, s, y, k0, k1;
    est_t e;
    a00 = p00; a01 = p01; a10 = p10; a11 = p11;
    if (it.cmd == gak_pkg::CMD_PREDICT) begin
      dt = longint'(it.dt);
      dt2 = (dt * dt + (longint'(1) << (gak_pkg::DT_FRAC - 1))) >>> gak_pkg::DT_FRAC;
      angle_m = clip(angle_m + mulr(longint'(it.rate) - bias_m, dt, gak_pkg::DT_FRAC), 32);
      t = a00 - mulr(a10 + a01, dt, gak_pkg::DT_FRAC) + mulr(a11, dt2, gak_pkg::DT_FRAC)
          + noise_cov(q_angle);
      p00 = clip(t, 48);
      t = mulr(a11, dt, gak_pkg::DT_FRAC);
      p01 = clip(a01 - t, 48);
      p10 = clip(a10 - t, 48);
      p11 = clip(a11 + noise_cov(q_bias), 48);
    end else begin
      s = a00 + noise_cov(r_meas);
      if (s > 0) begin
        y = clip(longint'(it.meas) - angle_m, 32);
        k0 = gain_quot(a00, s);
        k1 = gain_quot(a10, s);
        angle_m = clip(angle_m + mulr(y, k0, gak_pkg::GAIN_FRAC), 32);
        bias_m = clip(bias_m + mulr(y, k1, gak_pkg::GAIN_FRAC), 32);
        p00 = clip(a00 - mulr(a00, k0, gak_pkg::GAIN_FRAC), 48);
        p01 = clip(a01 - mulr(a01, k0, gak_pkg::GAIN_FRAC), 48);
        p10 = clip(a10 - mulr(a00, k1, gak_pkg::GAIN_FRAC), 48);
        p11 = clip(a11 - mulr(a01, k1, gak_pkg::GAIN_FRAC), 48);
      end
    end
    e.angle = angle_m[31:0];
    e.bias = bias_m[31:0];
    expected_estimates.push_back(e);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= gak_pkg::CMD_PREDICT;
      in_ch.gyro_rate <= '0;
      in_ch.time_step <= '0;
      in_ch.measured_angle <= '0;
      in_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) filter_step(pending_items.pop_front());
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        in_gap <= $urandom_range(0, 12);
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        item_t nx;
        nx = pending_items[0];
        in_ch.valid <= 1'b1;
        in_ch.cmd <= nx.cmd;
        in_ch.gyro_rate <= nx.rate;
        in_ch.time_step <= nx.dt;
        in_ch.measured_angle <= nx.meas;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_estimates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transaction angle=%0d bias=%0d",
                     out_ch.angle_estimate, out_ch.bias_estimate);
        end else begin
          est_t e;
          e = expected_estimates.pop_front();
          if (e.angle !== out_ch.angle_estimate || e.bias !== out_ch.bias_estimate) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp angle=%0d bias=%0d got angle=%0d bias=%0d",
                       e.angle, e.bias, out_ch.angle_estimate, out_ch.bias_estimate);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 12);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      gak_pkg::REG_NOISE_ANGLE: q_angle = val;
      gak_pkg::REG_NOISE_BIAS:  q_bias = val;
      gak_pkg::REG_NOISE_MEAS:  r_meas = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_estimates.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic item_t rand_item(int mode);
    item_t it;
    it.cmd = $urandom_range(0, 2) == 0 ? gak_pkg::CMD_UPDATE : gak_pkg::CMD_PREDICT;
    it.rate = $urandom;
    it.dt = 16'($urandom);
    it.meas = $urandom;
    if (mode != 0) begin
      it.rate = $signed(it.rate) >>> $urandom_range(8, 20);
      it.meas = $signed(it.meas) >>> $urandom_range(10, 20);
      it.dt = it.dt >> $urandom_range(4, 12);
    end
    return it;
  endfunction

  task automatic push(logic c, logic [31:0] r, logic [15:0] d, logic [31:0] m);
    item_t it;
    it.cmd = c; it.rate = r; it.dt = d; it.meas = m;
    pending_items.push_back(it);
  endtask

  initial begin
    logic [31:0] cfg_set[3];
    q_angle = gak_pkg::RST_NOISE_ANGLE;
    q_bias = gak_pkg::RST_NOISE_BIAS;
    r_meas = gak_pkg::RST_NOISE_MEAS;
    angle_m = 0; bias_m = 0; p00 = 0; p01 = 0; p10 = 0; p11 = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    push(gak_pkg::CMD_UPDATE, '0, '0, 32'h7FFF_FFFF);
    push(gak_pkg::CMD_PREDICT, 32'h7FFF_FFFF, 16'hFFFF, '0);
    push(gak_pkg::CMD_PREDICT, 32'h8000_0000, 16'hFFFF, 32'hFFFF_FFFF);
    push(gak_pkg::CMD_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 32'h8000_0000);
    push(gak_pkg::CMD_PREDICT, 32'h0001_0000, 16'h0000, '0);
    push(gak_pkg::CMD_UPDATE, '0, '0, 32'h7FFF_FFFF);
    push(gak_pkg::CMD_PREDICT, 32'h0000_8000, 16'h0100, '0);
    push(gak_pkg::CMD_UPDATE, '0, '0, 32'h0001_0000);
    drain();
    apb_write(gak_pkg::REG_NOISE_MEAS, 32'd0);
    apb_write(gak_pkg::REG_NOISE_ANGLE, 32'd0);
    apb_write(gak_pkg::REG_NOISE_BIAS, 32'd0);
    push(gak_pkg::CMD_UPDATE, '0, '0, 32'h0000_1000);
    push(gak_pkg::CMD_PREDICT, 32'h0010_0000, 16'h8000, '0);
    push(gak_pkg::CMD_UPDATE, '0, '0, 32'h8000_0000);
    drain();
    apb_write(gak_pkg::REG_NOISE_ANGLE, 32'hFFFF_FFFF);
    apb_write(gak_pkg::REG_NOISE_BIAS, 32'hFFFF_FFFF);
    apb_write(gak_pkg::REG_NOISE_MEAS, 32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++)
      push((i % 2 == 0) ? gak_pkg::CMD_PREDICT : gak_pkg::CMD_UPDATE,
           32'h7FFF_FFFF, 16'hFFFF, 32'h8000_0000);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      cfg_set[0] = ph == 3 ? 32'd85899 : $urandom;
      cfg_set[1] = ph == 3 ? 32'd429496730 : $urandom;
      cfg_set[2] = ph == 3 ? 32'd1 : $urandom;
      apb_write(gak_pkg::REG_NOISE_ANGLE, cfg_set[0]);
      apb_write(gak_pkg::REG_NOISE_BIAS, cfg_set[1]);
      apb_write(gak_pkg::REG_NOISE_MEAS, cfg_set[2]);
      if (ph == 3) idle_enable = 1'b0;
      for (int i = 0; i < 400; i++) pending_items.push_back(rand_item(i % 4 != 0));
      drain();
    end
    if (mismatch_count == 0 && expected_estimates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end
endmodule

### gyro_angle_kalman_filter.f
rtl/gak_pkg.sv
rtl/gak_in_if.sv
rtl/gak_out_if.sv
rtl/gak_mul.sv
rtl/gak_div.sv
rtl/gak_datapath.sv
rtl/gak_ctrl.sv
rtl/gyro_angle_kalman_filter.sv
bench/tb_top.sv
